[rtl/pfta_pkg.sv]
// Shared types, constants and helpers for the PID filter table with aging.
// Used by pfta_cell and pid_filter_table_aging_replace. No dependencies.
package pfta_pkg;

   localparam int TABLE_SLOTS = 39;
   localparam int AGE_BITS    = 16;
   localparam int PID_W       = 13;
   localparam int ACTION_W    = 3;
   localparam int SLOT_W      = 6;
   localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int FILL_W      = $clog2(TABLE_SLOTS + 1);

   localparam logic [ACTION_W-1:0] ACT_NONE      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REFRESHED = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_APPENDED  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REPLACED  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FULL_FAIL = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_RELEASED  = 3'd5;

   localparam logic OP_ADD     = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic [PID_W-1:0]    pid;
      logic                temp;
      logic [AGE_BITS-1:0] age;
   } entry_type;

   // slot number on the result port, low bits only
   function automatic logic [SLOT_W-1:0] slot_field(input logic [FILL_W-1:0] v);
      logic [FILL_W+SLOT_W-1:0] w;
      w = (FILL_W + SLOT_W)'(v);
      return w[SLOT_W-1:0];
   endfunction

   function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
      return (a == {AGE_BITS{1'b1}}) ? a : a + AGE_BITS'(1);
   endfunction

endpackage

[rtl/pfta_cell.sv]
// One slot of the rotating filter table: holds a PID, its temporary flag and age.
// Loads its neighbor's entry whenever the ring shifts. Uses pfta_pkg.
module pfta_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  pfta_pkg::entry_type  entry_d,
   output pfta_pkg::entry_type  entry_q
);

   pfta_pkg::entry_type entry_ff;
   pfta_pkg::entry_type entry_in;

   always_comb begin
      entry_in = shift ? entry_d : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

[rtl/pid_filter_table_aging_replace.sv]
// PID filter table with aging and replacement of temporary entries.
// Top level: ring of pfta_cell slots plus the head sequencer. Uses pfta_pkg.
//
// The table is a ring of TABLE_SLOTS cells that rotates one slot per cycle
// while scanning or evicting, past a single head unit; a request takes one
// full rotation, then a decision state and a response state. An add that
// misses on a full table needs a second rotation to overwrite a temporary
// victim. With demux_free set a request is answered in the cycle after
// acceptance without touching the table. One request is in flight at a
// time; req_stall is high from acceptance until the response item has been
// taken.
module pid_filter_table_aging_replace (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [pfta_pkg::PID_W-1:0]      req_pid,
   input  logic                            req_temporary,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_ok,
   output logic                            rsp_was_present,
   output logic [pfta_pkg::ACTION_W-1:0]   rsp_action,
   output logic [pfta_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [pfta_pkg::PID_W-1:0]      rsp_evicted_pid
);

   typedef enum logic [2:0] {IDLE, SCAN, DECIDE, EVICT, RESP} state_type;

   state_type                         state_ff, state_in;
   logic                              demux_free_ff, demux_free_in;
   logic                              failed_ff, failed_in;
   logic [pfta_pkg::FILL_W-1:0]       filled_ff, filled_in;
   logic [pfta_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic                              op_ff, op_in;
   logic [pfta_pkg::PID_W-1:0]        pid_ff, pid_in;
   logic                              tmp_ff, tmp_in;
   logic                              age_on_ff, age_on_in;
   logic                              hit_ff, hit_in;
   logic [pfta_pkg::IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic                              appended_ff, appended_in;
   logic                              best_found_ff, best_found_in;
   logic [pfta_pkg::IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [pfta_pkg::AGE_BITS-1:0]     best_age_ff, best_age_in;
   logic [pfta_pkg::PID_W-1:0]        best_pid_ff, best_pid_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic                              rsp_present_ff, rsp_present_in;
   logic [pfta_pkg::ACTION_W-1:0]     rsp_action_ff, rsp_action_in;
   logic [pfta_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [pfta_pkg::PID_W-1:0]        rsp_evicted_ff, rsp_evicted_in;

   pfta_pkg::entry_type               cell_q [pfta_pkg::TABLE_SLOTS];
   pfta_pkg::entry_type               head, head_new;
   logic                              shift;
   logic [pfta_pkg::FILL_W-1:0]       idx_ext;
   logic                              last, live, match;
   logic [pfta_pkg::AGE_BITS-1:0]     aged;

   // ring: cell 0 is the head, the head unit's output re-enters at the tail
   for (genvar k = 0; k < pfta_pkg::TABLE_SLOTS; k++) begin : g_ring
      pfta_pkg::entry_type cell_d;
      if (k == pfta_pkg::TABLE_SLOTS - 1) begin : g_tail
         assign cell_d = head_new;
      end else begin : g_body
         assign cell_d = cell_q[k+1];
      end
      pfta_cell u_cell (
         .clock   (clock),
         .shift   (shift),
         .entry_d (cell_d),
         .entry_q (cell_q[k])
      );
   end

   assign head    = cell_q[0];
   assign shift   = (state_ff == SCAN) || (state_ff == EVICT);
   assign idx_ext = pfta_pkg::FILL_W'(idx_ff);
   assign last    = (idx_ff == pfta_pkg::IDX_W'(pfta_pkg::TABLE_SLOTS - 1));
   assign live    = (idx_ext < filled_ff);
   assign match   = live && (head.pid == pid_ff);
   assign aged    = age_on_ff ? pfta_pkg::age_inc(head.age) : head.age;

   always_comb begin
      state_in       = state_ff;
      demux_free_in  = csr_we ? csr_wdata : demux_free_ff;
      failed_in      = failed_ff;
      filled_in      = filled_ff;
      idx_in         = idx_ff;
      op_in          = op_ff;
      pid_in         = pid_ff;
      tmp_in         = tmp_ff;
      age_on_in      = age_on_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      appended_in    = appended_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      best_pid_in    = best_pid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_present_in = rsp_present_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_evicted_in = rsp_evicted_ff;
      head_new       = head;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               pid_in        = req_pid;
               tmp_in        = req_temporary;
               idx_in        = '0;
               hit_in        = 1'b0;
               hit_idx_in    = '0;
               appended_in   = 1'b0;
               best_found_in = 1'b0;
               best_idx_in   = '0;
               best_age_in   = '0;
               best_pid_in   = '0;
               age_on_in     = !failed_ff;
               if (demux_free_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_ok_in      = 1'b1;
                  rsp_present_in = 1'b1;
                  rsp_action_in  = pfta_pkg::ACT_NONE;
                  rsp_slot_in    = '0;
                  rsp_evicted_in = '0;
                  state_in       = RESP;
               end else begin
                  state_in = SCAN;
               end
            end
         end
         SCAN: begin
            if (live) begin
               head_new.age = aged;
               if (head.temp && (!best_found_ff || aged > best_age_ff)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = idx_ff;
                  best_age_in   = aged;
                  best_pid_in   = head.pid;
               end
            end
            if (match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               if (age_on_ff) begin
                  if (op_ff == pfta_pkg::OP_RELEASE) begin
                     head_new.temp = 1'b1;
                  end else begin
                     head_new.temp = tmp_ff;
                     head_new.age  = '0;
                  end
               end
            end
            // first free slot comes after every filled one, so hit_ff already covers the whole table
            if (age_on_ff && !hit_ff && (op_ff == pfta_pkg::OP_ADD) &&
                (idx_ext == filled_ff)) begin
               head_new.pid  = pid_ff;
               head_new.temp = tmp_ff;
               head_new.age  = '0;
               appended_in   = 1'b1;
            end
            idx_in = last ? '0 : idx_ff + pfta_pkg::IDX_W'(1);
            if (last) begin
               state_in = DECIDE;
            end
         end
         DECIDE: begin
            rsp_valid_in   = 1'b1;
            rsp_ok_in      = 1'b1;
            rsp_present_in = hit_ff;
            rsp_action_in  = pfta_pkg::ACT_NONE;
            rsp_slot_in    = '0;
            rsp_evicted_in = '0;
            state_in       = RESP;
            priority if (!age_on_ff) begin
               rsp_ok_in = 1'b0;
            end else if (op_ff == pfta_pkg::OP_RELEASE) begin
               if (hit_ff) begin
                  rsp_action_in = pfta_pkg::ACT_RELEASED;
                  rsp_slot_in   = pfta_pkg::slot_field(pfta_pkg::FILL_W'(hit_idx_ff));
               end
            end else if (hit_ff) begin
               rsp_action_in = pfta_pkg::ACT_REFRESHED;
               rsp_slot_in   = pfta_pkg::slot_field(pfta_pkg::FILL_W'(hit_idx_ff));
            end else if (appended_ff) begin
               rsp_action_in = pfta_pkg::ACT_APPENDED;
               rsp_slot_in   = pfta_pkg::slot_field(filled_ff);
               filled_in     = filled_ff + pfta_pkg::FILL_W'(1);
            end else if (best_found_ff) begin
               rsp_valid_in   = 1'b0;
               rsp_action_in  = pfta_pkg::ACT_REPLACED;
               rsp_slot_in    = pfta_pkg::slot_field(pfta_pkg::FILL_W'(best_idx_ff));
               rsp_evicted_in = best_pid_ff;
               state_in       = EVICT;
            end else begin
               rsp_ok_in     = 1'b0;
               rsp_action_in = pfta_pkg::ACT_FULL_FAIL;
               failed_in     = 1'b1;
            end
         end
         EVICT: begin
            if (idx_ff == best_idx_ff) begin
               head_new.pid  = pid_ff;
               head_new.temp = tmp_ff;
               head_new.age  = '0;
            end
            idx_in = last ? '0 : idx_ff + pfta_pkg::IDX_W'(1);
            if (last) begin
               rsp_valid_in = 1'b1;
               state_in     = RESP;
            end
         end
         RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pid_ff         <= pid_in;
      tmp_ff         <= tmp_in;
      age_on_ff      <= age_on_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      appended_ff    <= appended_in;
      best_found_ff  <= best_found_in;
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      best_pid_ff    <= best_pid_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_present_ff <= rsp_present_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_evicted_ff <= rsp_evicted_in;
      if (reset) begin
         state_ff      <= IDLE;
         demux_free_ff <= 1'b0;
         failed_ff     <= 1'b0;
         filled_ff     <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         demux_free_ff <= demux_free_in;
         failed_ff     <= failed_in;
         filled_ff     <= filled_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_stall       = (state_ff != IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_action      = rsp_action_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_evicted_pid = rsp_evicted_ff;

endmodule
